// ----- hw/rtl/ptfr_pkg.sv -----
// shared types and constants for the page table with frame replacement
`timescale 1ns / 1ps
`default_nettype none
package ptfr_pkg;
  localparam int FRAMES    = 16;
  localparam int FRAME_W   = 4;
  localparam int PROC_W    = 3;
  localparam int PAGE_W    = 6;
  localparam int ENT_W     = PROC_W + PAGE_W;
  localparam int ENTRIES   = 1 << ENT_W;
  localparam int TIME_BITS = 32;
  localparam int CNT_W     = 32;
  localparam int FC_W      = 5;
  localparam int POL_W     = 2;
  localparam int CFG_W     = 5;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 80;
  localparam int PTE_W     = FRAME_W + 2;

  localparam logic [FC_W-1:0]  FC_RESET  = FC_W'(FRAMES);
  localparam logic [POL_W-1:0] POL_FIFO  = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU   = 2'd1;
  localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_POLICY      = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic hit_upd;
    logic fault_start;
    logic free_step;
    logic old_step;
    logic clk_init;
    logic clk_step;
    logic ev_read;
    logic ev_write;
    logic load;
    logic deliver;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic entry_valid;
    logic free_found;
    logic scan_last;
    logic policy_clock;
    logic clk_found;
    logic chosen_occ;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ptfr_ctrl.sv -----
// sequencing state machine for lookup, victim search and load
`timescale 1ns / 1ps
`default_nettype none
module ptfr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire ptfr_pkg::sts_t sts,
  output ptfr_pkg::cmd_t      cmd
);
  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_LOOK = 10'b0000000100,
    S_FREE = 10'b0000001000,
    S_OLD  = 10'b0000010000,
    S_CLK  = 10'b0000100000,
    S_EVRD = 10'b0001000000,
    S_EVWR = 10'b0010000000,
    S_LOAD = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.entry_valid) begin
          cmd.hit_upd = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.fault_start = 1'b1;
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_found) begin
          state_next = S_LOAD;
        end else if (sts.scan_last) begin
          if (sts.policy_clock) begin
            cmd.clk_init = 1'b1;
            state_next = S_CLK;
          end else begin
            state_next = S_OLD;
          end
        end
      end
      S_OLD: begin
        cmd.old_step = 1'b1;
        if (sts.scan_last) state_next = S_EVRD;
      end
      S_CLK: begin
        cmd.clk_step = 1'b1;
        if (sts.clk_found) state_next = S_EVRD;
      end
      S_EVRD: begin
        if (sts.chosen_occ) begin
          cmd.ev_read = 1'b1;
          state_next = S_EVWR;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_EVWR: begin
        cmd.ev_write = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.deliver = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) cmd.accept |=> state == S_LOOK)
    else $error("accept did not start a lookup");
  assert property (@(posedge clk) disable iff (rst) cmd.ev_write |-> $past(cmd.ev_read))
    else $error("eviction write without owner read");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_DONE)
    else $error("load not followed by result");
endmodule
`default_nettype wire

// ----- hw/rtl/ptfr_dp.sv -----
// datapath: page table memory, frame state, counters, config and result register
`timescale 1ns / 1ps
`default_nettype none
module ptfr_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptfr_pkg::cmd_t                cmd,
  output ptfr_pkg::sts_t                     sts,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [ptfr_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [ptfr_pkg::IN_W-1:0]     in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ptfr_pkg::OUT_W-1:0]         out_data
);
  localparam int FW = ptfr_pkg::FRAME_W;
  localparam int TW = ptfr_pkg::TIME_BITS;
  localparam int CW = ptfr_pkg::CNT_W;
  localparam int EW = ptfr_pkg::ENT_W;
  localparam int NF = ptfr_pkg::FRAMES;

  // page table entry: valid, dirty, frame
  logic [ptfr_pkg::PTE_W-1:0] pt_mem [ptfr_pkg::ENTRIES];
  logic [ptfr_pkg::PTE_W-1:0] rdata;
  logic [EW-1:0] raddr, waddr, clr_idx;
  logic [ptfr_pkg::PTE_W-1:0] wdata;
  logic we;

  logic [ptfr_pkg::FC_W-1:0]  frame_count;
  logic [ptfr_pkg::POL_W-1:0] policy;

  logic [ptfr_pkg::PROC_W-1:0] own_proc [NF];
  logic [ptfr_pkg::PAGE_W-1:0] own_page [NF];
  logic [NF-1:0] occ, refb;
  logic [TW-1:0] fill_time [NF];
  logic [TW-1:0] use_time  [NF];

  logic [FW-1:0] hand, idx, chosen, nm1, hand_inc;
  logic [TW-1:0] now, best_age, age;
  logic [CW-1:0] access_cnt, fault_cnt;

  // latched item
  logic [ptfr_pkg::PROC_W-1:0] cur_proc;
  logic [ptfr_pkg::PAGE_W-1:0] cur_page;
  logic cur_wr, cur_dirty;

  // result staging
  logic [FW-1:0] res_frame;
  logic res_hit, res_ev, res_dirty;
  logic [ptfr_pkg::PROC_W-1:0] res_evp;
  logic [ptfr_pkg::PAGE_W-1:0] res_evg;

  // active frame count clamped to 1..FRAMES, as last index
  always_comb begin
    if (frame_count == '0) nm1 = '0;
    else if (frame_count > ptfr_pkg::FC_W'(NF)) nm1 = FW'(NF - 1);
    else nm1 = FW'(frame_count - 1'b1);
  end

  assign age      = now - (policy == ptfr_pkg::POL_LRU ? use_time[idx] : fill_time[idx]);
  assign hand_inc = (hand == nm1) ? '0 : hand + 1'b1;

  assign sts.clr_last     = (clr_idx == EW'(ptfr_pkg::ENTRIES - 1));
  assign sts.entry_valid  = rdata[FW+1];
  assign sts.free_found   = !occ[idx];
  assign sts.scan_last    = (idx == nm1);
  assign sts.policy_clock = (policy == ptfr_pkg::POL_CLOCK);
  assign sts.clk_found    = !occ[hand] || !refb[hand];
  assign sts.chosen_occ   = occ[chosen];
  assign sts.out_free     = !out_valid || out_ready;

  // memory port muxing, entry address is process then page
  always_comb begin
    raddr = cmd.ev_read ? {own_proc[chosen], own_page[chosen]}
                        : {in_data[ptfr_pkg::PROC_W-1:0], in_data[EW-1:ptfr_pkg::PROC_W]};
    we    = 1'b0;
    waddr = {cur_proc, cur_page};
    wdata = '0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_idx;
    end else if (cmd.hit_upd) begin
      we    = 1'b1;
      wdata = {1'b1, rdata[FW] | cur_wr, rdata[FW-1:0]};
    end else if (cmd.ev_write) begin
      we    = 1'b1;
      waddr = {res_evp, res_evg};
      wdata = {1'b0, rdata[FW], {FW{1'b0}}};
    end else if (cmd.load) begin
      we    = 1'b1;
      wdata = {1'b1, cur_dirty | cur_wr, chosen};
    end
  end

  always_ff @(posedge clk) begin
    if (we) pt_mem[waddr] <= wdata;
    rdata <= pt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= ptfr_pkg::FC_RESET;
      policy      <= ptfr_pkg::POL_FIFO;
    end else if (cfg_we) begin
      if (cfg_index == ptfr_pkg::REG_FRAME_COUNT) frame_count <= cfg_data;
      else policy <= cfg_data[ptfr_pkg::POL_W-1:0];
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      refb       <= '0;
      hand       <= '0;
      idx        <= '0;
      now        <= '0;
      access_cnt <= '0;
      fault_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        now        <= now + 1'b1;
        access_cnt <= access_cnt + 1'b1;
      end
      if (cmd.fault_start) fault_cnt <= fault_cnt + 1'b1;
      if (cmd.hit_upd) refb[rdata[FW-1:0]] <= 1'b1;
      if (cmd.free_step || cmd.old_step) begin
        if (sts.scan_last || (cmd.free_step && sts.free_found)) idx <= '0;
        else idx <= idx + 1'b1;
      end
      if (cmd.clk_init && hand > nm1) hand <= '0;
      if (cmd.clk_step && occ[hand]) begin
        if (refb[hand]) refb[hand] <= 1'b0;
        hand <= hand_inc;
      end
      if (cmd.load) begin
        occ[chosen]  <= 1'b1;
        refb[chosen] <= 1'b1;
      end
      if (cmd.deliver) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_proc <= in_data[ptfr_pkg::PROC_W-1:0];
      cur_page <= in_data[EW-1:ptfr_pkg::PROC_W];
      cur_wr   <= in_data[EW];
      res_ev   <= 1'b0;
      res_evp  <= '0;
      res_evg  <= '0;
    end
    if (cmd.hit_upd) begin
      use_time[rdata[FW-1:0]] <= now;
      res_frame <= rdata[FW-1:0];
      res_hit   <= 1'b1;
      res_dirty <= rdata[FW] | cur_wr;
    end
    if (cmd.fault_start) begin
      cur_dirty <= rdata[FW];
      best_age  <= '0;
    end
    if (cmd.free_step && sts.free_found) chosen <= idx;
    if (cmd.old_step && (idx == '0 || age > best_age)) begin
      best_age <= age;
      chosen   <= idx;
    end
    if (cmd.clk_step && sts.clk_found) chosen <= hand;
    if (cmd.ev_read) begin
      res_ev  <= 1'b1;
      res_evp <= own_proc[chosen];
      res_evg <= own_page[chosen];
    end
    if (cmd.load) begin
      own_proc[chosen]  <= cur_proc;
      own_page[chosen]  <= cur_page;
      fill_time[chosen] <= now;
      use_time[chosen]  <= now;
      res_frame <= chosen;
      res_hit   <= 1'b0;
      res_dirty <= cur_dirty | cur_wr;
    end
    if (cmd.deliver) begin
      out_data <= {fault_cnt, access_cnt, res_dirty, res_evg, res_evp, res_ev,
                   res_hit, res_frame};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !cmd.fault_start && !$past(rst) |=> $stable(fault_cnt) || $past(cmd.fault_start))
    else $error("fault counter moved without a fault");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> occ[$past(chosen)])
    else $error("loaded frame not marked occupied");
  assert property (@(posedge clk) disable iff (rst) cmd.deliver |=> out_valid)
    else $error("result lost");
endmodule
`default_nettype wire

// ----- hw/rtl/page_table_with_frame_replacement_unit.sv -----
// top level of the page table with frame replacement
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tdata: proc, page_index, is_write
// m_axis   out  tvalid/tready    tdata: frame .. fault_count
// cfg      in   cfg_we           cfg_index 0 frame_count, 1 policy
//
// a hit goes from accept through the lookup to the result; a fault scans for a
// free frame, then, when none is free, compares ages for fifo and lru (one frame per
// cycle through the age compare) or sweeps the clock hand over the active frames,
// before any eviction and the load
// after reset a pass clears all 512 page table entries; no beat is taken then
// one item at a time; a finished beat waits in the output register while
// the next item is already being looked up
`timescale 1ns / 1ps
`default_nettype none
module page_table_with_frame_replacement_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] proc, [8:3] page_index, [9] is_write, zero fill
  input  wire logic [ptfr_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [3:0] frame, [4] hit, [5] evicted, [8:6] evicted_process,
  // [14:9] evicted_page, [15] page_dirty, [47:16] access_count,
  // [79:48] fault_count
  output logic [ptfr_pkg::OUT_W-1:0]          m_axis_tdata,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [ptfr_pkg::CFG_W-1:0]     cfg_data
);
  ptfr_pkg::cmd_t cmd;
  ptfr_pkg::sts_t sts;

  // controller: sequences lookup, scans and memory accesses
  ptfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table memory, frame state, counters, result beat
  ptfr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );
endmodule
`default_nettype wire
